// File: design/hcs_pkg.sv
// Shared types and constants for the chained hash set core.
// No dependencies; used by every module of the block but hcs_heads.
package hcs_pkg;

  localparam int KEY_W    = 31;
  localparam int BUCKET_W = 10;
  localparam int TSIZE_W  = 11;
  localparam int CFG_W    = 11;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CFG_W-1:0] RESET_SIZE = 11'd4;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [BUCKET_W-1:0] bucket;
    logic [TSIZE_W-1:0]  table_size;
    logic                resized;
    logic                dropped;
  } out_t;

endpackage

// File: design/hcs_mod.sv
// Iterative remainder unit: key mod size, one quotient bit per cycle.
// Depends on hcs_pkg for the key width.
module hcs_mod #(
  parameter int SW = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hcs_pkg::KEY_W-1:0] dividend,
  input  logic [SW-1:0]            divisor,
  output logic                     done,
  output logic [SW-1:0]            rem
);

  localparam int CNT_W = $clog2(hcs_pkg::KEY_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [hcs_pkg::KEY_W-1:0] dvd;
  logic [SW-1:0]             dsr;
  logic [SW:0]               trial;
  logic                      fits;

  assign trial = {rem, dvd[hcs_pkg::KEY_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(hcs_pkg::KEY_W - 1);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        // Restoring step; the remainder always stays below the divisor.
        rem <= fits ? SW'(trial - {1'b0, dsr}) : trial[SW-1:0];
        dvd <= {dvd[hcs_pkg::KEY_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/hcs_heads.sv
// Bucket head memory: one write port, one registered read port.
// Depends on nothing; the pointer width comes from the top level.
module hcs_heads #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/hcs_nodes.sv
// Node pool memory: key and link per node, separate write enables,
// one shared registered read port. Depends on hcs_pkg for the key width.
module hcs_nodes #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int PW    = 11
) (
  input  logic                      clk,
  input  logic                      key_we,
  input  logic                      link_we,
  input  logic [AW-1:0]             waddr,
  input  logic [hcs_pkg::KEY_W-1:0] wkey,
  input  logic [PW-1:0]             wlink,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [hcs_pkg::KEY_W-1:0] rkey,
  output logic [PW-1:0]             rlink
);

  logic [hcs_pkg::KEY_W-1:0] keys  [DEPTH];
  logic [PW-1:0]             links [DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      keys[waddr] <= wkey;
    end
    if (link_we) begin
      links[waddr] <= wlink;
    end
    if (re) begin
      rkey  <= keys[raddr];
      rlink <= links[raddr];
    end
  end

endmodule

// File: design/chained_hash_set_with_resize_core.sv
// Channel  Dir  Handshake              Beat
// in       in   in_valid / in_ready    hcs_pkg::in_t  {op, key}
// out      out  out_valid / out_ready  hcs_pkg::out_t, result fields in struct order
// cfg      in   cfg_we                 cfg_data, initial bucket count
// From accept to result: a lookup runs the remainder unit, reads the bucket head and
// walks the chain; an insert runs it and links the new node at its bucket head. Most
// of this time is the 31-step remainder unit. A resize clears the head memory, then
// relinks each stored key. After reset and after a cfg write taken while idle or in a
// clear pass not begun by a resize, the head memory is cleared with in_ready low;
// other cfg writes are ignored. A held result does not block the next input beat.
// Top level of the chained hash set; uses hcs_pkg, hcs_mod, hcs_heads, hcs_nodes.
module chained_hash_set_with_resize_core #(
  parameter int MAX_BUCKETS = 1024,
  parameter int NODE_POOL   = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hcs_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hcs_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [hcs_pkg::CFG_W-1:0] cfg_data
);

  localparam int SW = $clog2(MAX_BUCKETS + 1);
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int AW = $clog2(NODE_POOL);
  localparam int NW = AW + 1;
  localparam int LW = ((NW > SW) ? NW : SW) + 3;
  localparam int IW = ((SW > hcs_pkg::CFG_W) ? SW : hcs_pkg::CFG_W) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_USE, S_WALK, S_CMP, S_RH, S_RHK, S_INS, S_DONE
  } state_t;

  typedef enum logic [1:0] {M_LOOK, M_LINK_RH, M_LINK_INS, M_DROP} mode_t;

  state_t                    state;
  mode_t                     mode;
  logic                      ret_rh;
  logic [BW-1:0]             clr_cnt;
  logic [SW-1:0]             size;
  logic [NW-1:0]             count;
  logic [NW-1:0]             idx;
  logic [NW-1:0]             node;
  logic [NW-1:0]             walk;
  logic [hcs_pkg::KEY_W-1:0] key_q;
  logic                      found_q;
  logic                      resized_q;
  logic                      dropped_q;
  logic [SW-1:0]             rem_q;
  logic                      div_start;
  logic [hcs_pkg::KEY_W-1:0] div_key;

  logic                      div_done;
  logic [SW-1:0]             div_rem;
  logic                      heads_we;
  logic [BW-1:0]             heads_waddr;
  logic [NW-1:0]             heads_wdata;
  logic                      heads_re;
  logic [NW-1:0]             heads_rdata;
  logic                      key_we;
  logic                      link_we;
  logic [AW-1:0]             nodes_waddr;
  logic                      nodes_re;
  logic [AW-1:0]             nodes_raddr;
  logic [hcs_pkg::KEY_W-1:0] rkey;
  logic [NW-1:0]             rlink;
  logic [BW-1:0]             bidx;
  logic                      pool_full;
  logic                      grow;
  logic [SW:0]               doubled;
  logic [SW-1:0]             grown;
  logic [SW-1:0]             cfg_size;
  logic [SW-1:0]             reset_size;

  function automatic logic [SW-1:0] clamp_size(input logic [hcs_pkg::CFG_W-1:0] v);
    logic [IW-1:0] w;
    w = IW'(v);
    if (w == '0) begin
      return SW'(1);
    end else if (w > IW'(MAX_BUCKETS)) begin
      return SW'(MAX_BUCKETS);
    end
    return SW'(w);
  endfunction

  assign cfg_size   = clamp_size(cfg_data);
  assign reset_size = clamp_size(hcs_pkg::RESET_SIZE);
  assign bidx       = rem_q[BW-1:0];
  assign pool_full  = count >= NW'(NODE_POOL);
  assign grow       = ((LW'(count) << 2) > ((LW'(size) << 1) + LW'(size))) &&
                      (size < SW'(MAX_BUCKETS));
  assign doubled    = {size, 1'b0};
  assign grown      = (doubled > (SW + 1)'(MAX_BUCKETS)) ? SW'(MAX_BUCKETS) : doubled[SW-1:0];
  assign in_ready   = (state == S_IDLE) && !cfg_we;

  always_comb begin
    heads_we    = (state == S_CLEAR) || ((state == S_USE) && (mode != M_LOOK));
    heads_waddr = (state == S_CLEAR) ? clr_cnt : bidx;
    heads_wdata = (state == S_CLEAR) ? '1 : node;
    heads_re    = state == S_HEAD;
    key_we      = (state == S_INS) && !pool_full;
    link_we     = (state == S_USE) && (mode != M_LOOK);
    nodes_waddr = (state == S_INS) ? count[AW-1:0] : node[AW-1:0];
    nodes_re    = ((state == S_RH) && (idx < count)) || ((state == S_WALK) && (walk < count));
    nodes_raddr = (state == S_RH) ? idx[AW-1:0] : walk[AW-1:0];
  end

  hcs_mod #(.SW(SW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_key),
    .divisor (size),
    .done    (div_done),
    .rem     (div_rem)
  );

  hcs_heads #(.DEPTH(MAX_BUCKETS), .AW(BW), .DW(NW)) u_heads (
    .clk  (clk),
    .we   (heads_we),
    .waddr(heads_waddr),
    .wdata(heads_wdata),
    .re   (heads_re),
    .raddr(bidx),
    .rdata(heads_rdata)
  );

  hcs_nodes #(.DEPTH(NODE_POOL), .AW(AW), .PW(NW)) u_nodes (
    .clk    (clk),
    .key_we (key_we),
    .link_we(link_we),
    .waddr  (nodes_waddr),
    .wkey   (key_q),
    .wlink  (heads_rdata),
    .re     (nodes_re),
    .raddr  (nodes_raddr),
    .rkey   (rkey),
    .rlink  (rlink)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      mode      <= M_LOOK;
      ret_rh    <= 1'b0;
      clr_cnt   <= '0;
      size      <= reset_size;
      count     <= '0;
      idx       <= '0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cfg_we && !ret_rh) begin
            // A write during a clear pass not begun by a resize restarts it at the new size.
            size    <= cfg_size;
            count   <= '0;
            clr_cnt <= '0;
          end else if (clr_cnt == BW'(MAX_BUCKETS - 1)) begin
            clr_cnt <= '0;
            idx     <= '0;
            state   <= ret_rh ? S_RH : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (cfg_we) begin
            size   <= cfg_size;
            count  <= '0;
            ret_rh <= 1'b0;
            state  <= S_CLEAR;
          end else if (in_valid) begin
            key_q     <= in_data.key;
            found_q   <= 1'b0;
            resized_q <= (in_data.op == hcs_pkg::OP_INSERT) && grow;
            dropped_q <= 1'b0;
            if (in_data.op == hcs_pkg::OP_LOOKUP) begin
              mode      <= M_LOOK;
              div_key   <= in_data.key;
              div_start <= 1'b1;
              state     <= S_MOD;
            end else if (grow) begin
              size   <= grown;
              ret_rh <= 1'b1;
              state  <= S_CLEAR;
            end else begin
              state <= S_INS;
            end
          end
        end
        S_RH: begin
          node  <= idx;
          state <= (idx < count) ? S_RHK : S_INS;
        end
        S_RHK: begin
          div_key   <= rkey;
          div_start <= 1'b1;
          mode      <= M_LINK_RH;
          state     <= S_MOD;
        end
        S_INS: begin
          ret_rh    <= 1'b0;
          div_key   <= key_q;
          div_start <= 1'b1;
          node      <= count;
          if (pool_full) begin
            dropped_q <= 1'b1;
            mode      <= M_DROP;
          end else begin
            mode <= M_LINK_INS;
          end
          state <= S_MOD;
        end
        S_MOD: begin
          div_start <= 1'b0;
          if (div_done) begin
            rem_q <= div_rem;
            state <= (mode == M_DROP) ? S_DONE : S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_USE;
        end
        S_USE: begin
          case (mode)
            M_LOOK: begin
              walk  <= heads_rdata;
              state <= S_WALK;
            end
            M_LINK_RH: begin
              idx   <= idx + 1'b1;
              state <= S_RH;
            end
            M_LINK_INS: begin
              count <= count + 1'b1;
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_WALK: begin
          // An empty head reads as all ones, which is never below the count.
          state <= (walk < count) ? S_CMP : S_DONE;
        end
        S_CMP: begin
          if (rkey == key_q) begin
            found_q <= 1'b1;
            state   <= S_DONE;
          end else begin
            walk  <= rlink;
            state <= S_WALK;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.found      <= found_q;
            out_data.bucket     <= hcs_pkg::BUCKET_W'(rem_q);
            out_data.table_size <= hcs_pkg::TSIZE_W'(size);
            out_data.resized    <= resized_q;
            out_data.dropped    <= dropped_q;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/hcs_checker.sv
// Scoreboard for the chained hash set core: mirrors the table, predicts each result beat.
// Depends on hcs_pkg; instantiated beside the block by tb_chained_hash_set_with_resize_core.
module hcs_checker #(
  parameter int MAX_BUCKETS = 1024,
  parameter int NODE_POOL   = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  hcs_pkg::in_t              in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  hcs_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [hcs_pkg::CFG_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  int            chain_head [MAX_BUCKETS];
  int unsigned   node_key   [NODE_POOL];
  int            node_next  [NODE_POOL];
  int unsigned   stored;
  int unsigned   buckets;
  int unsigned   start_size;
  hcs_pkg::out_t expected_q [$];

  function automatic void clear_table();
    for (int i = 0; i < MAX_BUCKETS; i++) chain_head[i] = -1;
    stored = 0;
    if (start_size == 0) buckets = 1;
    else if (start_size > MAX_BUCKETS) buckets = MAX_BUCKETS;
    else buckets = start_size;
  endfunction

  function automatic void link_node(int n);
    int unsigned b;
    b = node_key[n] % buckets;
    node_next[n] = chain_head[b];
    chain_head[b] = n;
  endfunction

  function automatic bit key_present(int unsigned k);
    int n;
    n = chain_head[k % buckets];
    while (n >= 0) begin
      if (node_key[n] == k) return 1'b1;
      n = node_next[n];
    end
    return 1'b0;
  endfunction

  function automatic hcs_pkg::out_t table_access(hcs_pkg::in_t beat);
    hcs_pkg::out_t r;
    int unsigned grown;
    r = '0;
    if (beat.op == hcs_pkg::OP_INSERT) begin
      if (stored * 4 > buckets * 3 && buckets < MAX_BUCKETS) begin
        grown = buckets * 2;
        if (grown > MAX_BUCKETS) grown = MAX_BUCKETS;
        buckets = grown;
        for (int i = 0; i < MAX_BUCKETS; i++) chain_head[i] = -1;
        for (int i = 0; i < stored; i++) link_node(i);
        r.resized = 1'b1;
      end
      if (stored >= NODE_POOL) begin
        r.dropped = 1'b1;
      end else begin
        node_key[stored] = beat.key;
        link_node(stored);
        stored++;
      end
    end else begin
      r.found = key_present(beat.key);
    end
    r.bucket     = hcs_pkg::BUCKET_W'(beat.key % buckets);
    r.table_size = hcs_pkg::TSIZE_W'(buckets);
    return r;
  endfunction

  always @(posedge clk) begin
    hcs_pkg::out_t e;
    if (rst) begin
      start_size = hcs_pkg::RESET_SIZE;
      clear_table();
      expected_q.delete();
      fails = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        start_size = cfg_data;
        clear_table();
      end
      if (in_valid && in_ready) expected_q.push_back(table_access(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_data.found);
            fails++;
          end
          if (out_data.bucket !== e.bucket) begin
            $error("bucket: expected %0d, got %0d", e.bucket, out_data.bucket);
            fails++;
          end
          if (out_data.table_size !== e.table_size) begin
            $error("table_size: expected %0d, got %0d", e.table_size, out_data.table_size);
            fails++;
          end
          if (out_data.resized !== e.resized) begin
            $error("resized: expected %0d, got %0d", e.resized, out_data.resized);
            fails++;
          end
          if (out_data.dropped !== e.dropped) begin
            $error("dropped: expected %0d, got %0d", e.dropped, out_data.dropped);
            fails++;
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// File: test/tb_chained_hash_set_with_resize_core.sv
// Top of the hash set testbench: clock, reset, stimulus phases and the verdict.
// Depends on hcs_pkg, chained_hash_set_with_resize_core and hcs_checker.
module tb_chained_hash_set_with_resize_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  hcs_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  hcs_pkg::out_t             out_data;
  logic                      cfg_we = 1'b0;
  logic [hcs_pkg::CFG_W-1:0] cfg_data = '0;
  int                        fails;
  int                        pending;

  int          gap_pct;
  int          stall_pct;
  bit          hold_out;
  int unsigned recent_keys [64];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_hash_set_with_resize_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  hcs_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    out_ready <= !rst && !hold_out && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_beat(logic op, int unsigned key);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data.op   <= op;
    in_data.key  <= key[hcs_pkg::KEY_W-1:0];
    recent_keys[$urandom_range(63)] = key & 32'h7FFF_FFFF;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int unsigned pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return $urandom_range(63);
    if (sel < 6) return recent_keys[$urandom_range(63)];
    if (sel == 6) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  // Results always follow inputs, so an empty scoreboard means the core is idle.
  // The first edge lets the scoreboard record the last accepted beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_size(logic [hcs_pkg::CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_beats(int n, int lookup_pct);
    for (int i = 0; i < n; i++)
      send_beat(($urandom_range(99) < lookup_pct) ? hcs_pkg::OP_LOOKUP : hcs_pkg::OP_INSERT,
                pick_key());
  endtask

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    gap_pct   = 0;
    stall_pct = 0;
    hold_out  = 1'b0;
    foreach (recent_keys[i]) recent_keys[i] = i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: four buckets at reset, a shared chain, duplicates, a miss, the first resize.
    send_beat(hcs_pkg::OP_LOOKUP, 5);
    send_beat(hcs_pkg::OP_INSERT, 0);
    send_beat(hcs_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_beat(hcs_pkg::OP_INSERT, 1);
    send_beat(hcs_pkg::OP_INSERT, 5);
    send_beat(hcs_pkg::OP_INSERT, 5);
    send_beat(hcs_pkg::OP_INSERT, 9);
    send_beat(hcs_pkg::OP_LOOKUP, 5);
    send_beat(hcs_pkg::OP_LOOKUP, 9);
    send_beat(hcs_pkg::OP_LOOKUP, 13);
    send_beat(hcs_pkg::OP_LOOKUP, 32'h7FFF_FFFF);
    send_beat(hcs_pkg::OP_LOOKUP, 32'h5555_5555);
    send_beat(hcs_pkg::OP_INSERT, 32'h2AAA_AAAA);
    send_beat(hcs_pkg::OP_INSERT, 32'h5555_5555);
    send_beat(hcs_pkg::OP_LOOKUP, 32'h2AAA_AAAA);
    send_beat(hcs_pkg::OP_LOOKUP, 0);
    send_beat(hcs_pkg::OP_LOOKUP, 2);
    drain();

    // Size zero is taken as one bucket.
    load_size(11'd0);
    gap_pct = 61;
    random_beats(60, 40);
    drain();

    // Full size, receiver stalls and one long hold-off so the core backs up.
    load_size(11'd1024);
    gap_pct   = 0;
    stall_pct = 61;
    fork
      begin
        hold_out = 1'b1;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    random_beats(80, 50);
    drain();

    // Above the cap is taken as the cap.
    load_size(11'h7FF);
    gap_pct   = 18;
    stall_pct = 18;
    random_beats(60, 50);
    drain();

    // Odd start so the doubling stops at the cap; then fill the pool until inserts drop.
    load_size(11'd3);
    gap_pct   = 0;
    stall_pct = 0;
    random_beats(300, 3);
    gap_pct = 61;
    random_beats(200, 3);
    gap_pct   = 0;
    stall_pct = 61;
    random_beats(300, 3);
    gap_pct   = 18;
    stall_pct = 18;
    random_beats(300, 3);
    drain();

    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
